// ===== hw/rtl/dfap_pkg.sv =====
// Package with shared constants and the pipeline word type for the decimal packer.
package dfap_pkg;

  // Format defaults and fixed field widths.
  localparam int ExpBitsDef     = 5;
  localparam int AmountMantDef  = 35;
  localparam int FeeMantDef     = 11;
  localparam int AmountWidth    = 64;
  localparam int PackedWidth    = 40;
  localparam int MaxSteps       = 20;
  localparam int StepCntWidth   = 5;

  // Format selector codes.
  localparam logic CmdAmount = 1'b0;
  localparam logic CmdFee    = 1'b1;

  // Result codes.
  localparam logic ErrNone = 1'b0;
  localparam logic ErrLoss = 1'b1;

  // One word as it travels down the divide pipeline.
  typedef struct packed {
    logic                    valid;
    logic                    fee;
    logic [AmountWidth-1:0]  v;
    logic [StepCntWidth-1:0] e;
    logic                    done;
    logic                    err;
  } dfap_item_t;

endpackage

// ===== hw/rtl/dfap_in_if.sv =====
// Input channel interface: format selector and amount.
interface dfap_in_if
  import dfap_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [AmountWidth-1:0] amount;

  modport source (output valid, output command, output amount, input ready);
  modport sink (input valid, input command, input amount, output ready);
endinterface

// ===== hw/rtl/dfap_out_if.sv =====
// Output channel interface: packed word and error flag.
interface dfap_out_if
  import dfap_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [PackedWidth-1:0] packed_res;
  logic                   error_code;

  modport source (output valid, output packed_res, output error_code, input ready);
  modport sink (input valid, input packed_res, input error_code, output ready);
endinterface

// ===== hw/rtl/dfap_div10_stage.sv =====
// One divide-by-ten step of the packer, split over two register stages.
module dfap_div10_stage
  import dfap_pkg::*;
#(
  parameter int AMOUNT_MANTISSA_BITS = AmountMantDef,
  parameter int FEE_MANTISSA_BITS    = FeeMantDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  dfap_item_t din,
  output dfap_item_t dout
);

  localparam logic [AmountWidth-1:0] AmtLimit = AmountWidth'(1) << AMOUNT_MANTISSA_BITS;
  localparam logic [AmountWidth-1:0] FeeLimit = AmountWidth'(1) << FEE_MANTISSA_BITS;

  dfap_item_t             mid;
  logic [AmountWidth-1:0] mid_q;
  logic [AmountWidth-1:0] qa1, qa2, qa3;
  logic [AmountWidth-1:0] qb4, qb5, qb, rb, qf;
  logic                   corr, rem_nz, below;
  dfap_item_t             dout_next;

  // First half of the reciprocal estimate of v / 10.
  always_comb begin
    qa1 = (din.v >> 1) + (din.v >> 2);
    qa2 = qa1 + (qa1 >> 4);
    qa3 = qa2 + (qa2 >> 8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else if (en) begin
      mid   <= din;
      mid_q <= qa3;
    end
  end

  // Finish the estimate, correct it, and take one step of the strip loop.
  always_comb begin
    qb4    = mid_q + (mid_q >> 16);
    qb5    = qb4 + (qb4 >> 32);
    qb     = qb5 >> 3;
    rb     = mid.v - ((qb << 3) + (qb << 1));
    corr   = rb > AmountWidth'(9);
    qf     = qb + AmountWidth'(corr);
    rem_nz = corr ? (rb != AmountWidth'(10)) : (rb != '0);
    below  = (mid.fee == CmdFee) ? (mid.v < FeeLimit) : (mid.v < AmtLimit);
    dout_next = mid;
    if (!mid.done && !mid.err) begin
      if (below) begin
        dout_next.done = 1'b1;
      end else if (rem_nz) begin
        dout_next.err = 1'b1;
      end else begin
        dout_next.v = qf;
        dout_next.e = mid.e + StepCntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

// ===== hw/rtl/decimal_float_amount_packer_unit.sv =====
// Decimal packer: a 64-bit amount is stripped of trailing decimal zeros until it fits the
// selected mantissa (amount or fee format), then packed as mantissa above a decimal exponent.
// A word enters every cycle while the output is taken or empty, then passes through twenty
// divide-by-ten steps of two register stages each and an output register. The pipeline advances
// as one and holds when the output word is not taken; an unpackable amount gives error 1 and zero.
module decimal_float_amount_packer_unit
  import dfap_pkg::*;
#(
  parameter int EXP_BITS             = ExpBitsDef,
  parameter int AMOUNT_MANTISSA_BITS = AmountMantDef,
  parameter int FEE_MANTISSA_BITS    = FeeMantDef
) (
  input  logic     clk,
  input  logic     rst,
  dfap_in_if.sink  item,
  dfap_out_if.source result
);

  localparam logic [AmountWidth-1:0] AmtLimit = AmountWidth'(1) << AMOUNT_MANTISSA_BITS;
  localparam logic [AmountWidth-1:0] FeeLimit = AmountWidth'(1) << FEE_MANTISSA_BITS;

  logic       en;
  dfap_item_t pipe [MaxSteps+1];
  dfap_item_t last;
  logic       fin_err;
  logic [AmountWidth-1:0] fin_word;

  // The whole pipeline moves unless a finished word is waiting.
  assign en         = result.ready || !result.valid;
  assign item.ready = en;

  // Load the incoming word into the head of the pipeline.
  always_comb begin
    pipe[0].valid = item.valid;
    pipe[0].fee   = item.command;
    pipe[0].v     = item.amount;
    pipe[0].e     = '0;
    pipe[0].done  = (item.amount == '0);
    pipe[0].err   = 1'b0;
  end

  // Chain of divide-by-ten steps.
  for (genvar i = 0; i < MaxSteps; i++) begin : g_step
    dfap_div10_stage #(
      .AMOUNT_MANTISSA_BITS(AMOUNT_MANTISSA_BITS),
      .FEE_MANTISSA_BITS   (FEE_MANTISSA_BITS)
    ) u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .din (pipe[i]),
      .dout(pipe[i+1])
    );
  end

  // Final range check and packing. The exponent never exceeds twenty, so it fits the default five-bit exponent field.
  assign last    = pipe[MaxSteps];
  assign fin_err = last.err || (!last.done &&
                   ((last.fee == CmdFee) ? (last.v >= FeeLimit) : (last.v >= AmtLimit)));
  assign fin_word = (last.v << EXP_BITS) | AmountWidth'(last.e);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid      <= last.valid;
      result.error_code <= fin_err ? ErrLoss : ErrNone;
      result.packed_res <= fin_err ? '0 : fin_word[PackedWidth-1:0];
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.error_code == ErrLoss |-> result.packed_res == '0)
    else $error("error word carries a nonzero packed value");
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.error_code == ErrNone |->
    result.packed_res[EXP_BITS-1:0] <= EXP_BITS'(MaxSteps))
    else $error("exponent beyond the step count");
  a_rst_clear: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("output valid after reset");
  a_hold_tail: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pipe[MaxSteps]))
    else $error("pipeline tail moved during a stall");
`endif

endmodule

// ===== verif/decimal_float_amount_packer_unit_tb.sv =====
// Self-checking testbench for the decimal amount packer: directed table, then random words.
module decimal_float_amount_packer_unit_tb;
  import dfap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandWords = 1950;
  localparam int Latency = 41;

  typedef struct {
    logic                   fee;
    logic [AmountWidth-1:0] amount;
    bit                     typed;
    logic [PackedWidth-1:0] packed_exp;
    logic                   err_exp;
  } stim_row_t;

  typedef struct {
    logic [PackedWidth-1:0] packed_res;
    logic                   error_code;
  } packed_word_t;

  logic clk;
  logic rst;
  int   error_count;
  int   words_checked;
  int   loss_seen;
  bit   driving_done;
  packed_word_t pending_words[$];
  stim_row_t    directed_rows[$];

  dfap_in_if  item_ch ();
  dfap_out_if result_ch ();

  decimal_float_amount_packer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Strip trailing decimal zeros until the value fits the selected mantissa.
  function automatic packed_word_t pack_amount(logic fee, logic [AmountWidth-1:0] amount);
    packed_word_t            w;
    logic [AmountWidth-1:0]  v;
    logic [AmountWidth-1:0]  lim;
    int                      e;
    bit                      bad;
    v = amount;
    e = 0;
    bad = 1'b0;
    lim = (fee == CmdFee) ? (64'd1 << FeeMantDef) : (64'd1 << AmountMantDef);
    for (int k = 0; k < MaxSteps && v >= lim; k++) begin
      if (v % 10 != 0) begin
        bad = 1'b1;
        break;
      end
      v = v / 10;
      e++;
    end
    if (!bad && v >= lim) bad = 1'b1;
    if (!bad && e >= (1 << ExpBitsDef)) bad = 1'b1;
    if (bad) begin
      w.packed_res = '0;
      w.error_code = ErrLoss;
    end else begin
      w.packed_res = PackedWidth'((v << ExpBitsDef) | AmountWidth'(e));
      w.error_code = ErrNone;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void add_row(logic fee, logic [AmountWidth-1:0] amount, bit typed = 0,
                                  logic [PackedWidth-1:0] p = 0, logic e = 0);
    stim_row_t r;
    r.fee = fee;
    r.amount = amount;
    r.typed = typed;
    r.packed_exp = p;
    r.err_exp = e;
    directed_rows.push_back(r);
  endfunction

  // Random amounts biased toward small mantissas with trailing zeros.
  function automatic logic [AmountWidth-1:0] random_amount(logic fee);
    logic [AmountWidth-1:0] v;
    int mb;
    int zeros;
    mb = (fee == CmdFee) ? FeeMantDef : AmountMantDef;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = AmountWidth'($urandom_range(0, 3000));
      default: begin
        v = {$urandom, $urandom} & ((64'd1 << $urandom_range(1, mb + 1)) - 1);
        zeros = $urandom_range(0, 19);
        for (int k = 0; k < zeros; k++) begin
          if (v > 64'hFFFF_FFFF_FFFF_FFFF / 10) break;
          v = v * 10;
        end
        if ($urandom_range(0, 7) == 0) v = v + AmountWidth'($urandom_range(1, 9));
      end
    endcase
    return v;
  endfunction

  // Drive one word; valid drops only when an idle gap is drawn before the word.
  task automatic send_word(logic fee, logic [AmountWidth-1:0] amount);
    packed_word_t w;
    int idle;
    idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (idle > 0) begin
      item_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.command <= fee;
    item_ch.amount  <= amount;
    w = pack_amount(fee, amount);
    pending_words.push_back(w);
    if (w.error_code == ErrLoss) loss_seen++;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stimulus: directed table, then random words.
  initial begin
    logic fee;
    item_ch.valid = 1'b0;
    item_ch.command = CmdAmount;
    item_ch.amount = '0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(CmdAmount, 64'd0, 1, 40'd0, ErrNone);
    add_row(CmdFee, 64'd0, 1, 40'd0, ErrNone);
    add_row(CmdAmount, 64'd1, 1, 40'd32, ErrNone);
    add_row(CmdFee, 64'd2047, 1, 40'd2047 << 5, ErrNone);
    add_row(CmdFee, 64'd2048);
    add_row(CmdFee, 64'd2049, 1, 40'd0, ErrLoss);
    add_row(CmdFee, 64'd20480, 1, 40'd0, ErrLoss);
    add_row(CmdAmount, 64'd34359738367, 1, 40'd34359738367 << 5, ErrNone);
    add_row(CmdAmount, 64'd34359738368);
    add_row(CmdAmount, 64'd34359738369, 1, 40'd0, ErrLoss);
    add_row(CmdAmount, 64'hFFFF_FFFF_FFFF_FFFF, 1, 40'd0, ErrLoss);
    add_row(CmdFee, 64'hFFFF_FFFF_FFFF_FFFF, 1, 40'd0, ErrLoss);
    add_row(CmdAmount, 64'd10000000000000000000);
    add_row(CmdFee, 64'd10000000000000000000);
    add_row(CmdFee, 64'd1000000000000000000);
    add_row(CmdAmount, 64'h8000_0000_0000_0000);
    add_row(CmdFee, 64'd12340000000000000000);
    add_row(CmdAmount, 64'h5555_5555_5555_5550);
    add_row(CmdAmount, 64'hAAAA_AAAA_AAAA_AAA0);
    add_row(CmdFee, 64'd999000);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        packed_word_t w;
        w = pack_amount(directed_rows[i].fee, directed_rows[i].amount);
        if (w.packed_res !== directed_rows[i].packed_exp ||
            w.error_code !== directed_rows[i].err_exp)
          report_mismatch($sformatf("table row %0d disagrees with predictor", i));
      end
      send_word(directed_rows[i].fee, directed_rows[i].amount);
    end
    for (int i = 0; i < RandWords; i++) begin
      fee = 1'($urandom_range(0, 1));
      send_word(fee, random_amount(fee));
    end
    item_ch.valid <= 1'b0;
    driving_done = 1'b1;
  end

  // Receiver with random stalls, including long stall-free stretches.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Check each accepted word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result word with no expectation pending");
      end else begin
        packed_word_t w;
        w = pending_words.pop_front();
        words_checked++;
        if (result_ch.packed_res !== w.packed_res)
          report_mismatch($sformatf("packed_res got %h want %h",
                                    result_ch.packed_res, w.packed_res));
        if (result_ch.error_code !== w.error_code)
          report_mismatch($sformatf("error_code got %b want %b",
                                    result_ch.error_code, w.error_code));
      end
    end
  end

  // Completion.
  initial begin
    error_count = 0;
    words_checked = 0;
    loss_seen = 0;
    driving_done = 1'b0;
    wait (driving_done && pending_words.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    $display("Checked %0d packed words, %0d of them predicted unpackable.",
             words_checked, loss_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Timeout with %0d words still pending", pending_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
